FILE: rtl/core/ibusfr_pkg.sv
// Shared types and constants of the iBus frame receiver.
// Depends on nothing; used by the parser, the readout sequencer, the configuration register and the top level.
package ibusfr_pkg;

	// Frame layout
	localparam logic [4:0]  CSUM_LO_POS = 5'd30;
	localparam logic [4:0]  CSUM_HI_POS = 5'd31;
	localparam logic [7:0]  HDR0        = 8'h20;
	localparam logic [7:0]  HDR1        = 8'h40;
	localparam logic [15:0] CSUM_INIT   = 16'hFFFF;
	localparam logic [7:0]  LIMIT_RESET = 8'd10;

	// Item operations
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_HDR  = 2'd1;
	localparam logic [1:0] ST_BAD_SUM  = 2'd2;
	localparam logic [1:0] ST_FAILSAFE = 2'd3;

	typedef enum logic [1:0] {
		EV_GOOD,
		EV_BAD_HDR,
		EV_BAD_SUM,
		EV_FAILSAFE
	} ev_kind_t;

	// Frame event from parser to readout sequencer
	typedef struct packed {
		logic     valid;
		ev_kind_t kind;
	} ev_t;

endpackage

FILE: rtl/core/ibus_frame_receiver_core.sv
// iBus frame receiver: top level tying parser, channel RAM and readout sequencer.
// Depends on ibusfr_pkg, ibusfr_ram, ibusfr_parse, ibusfr_readout, ibusfr_cfg.
//
// Input channel (item_valid/item_ready): one word per UART byte (op = 0) or per
// missed-frame tick (op = 1). Bytes fill 32-byte frames by position alone.
// Output channel (result_valid/result_ready): result words with status, channel
// index, channel value and a last flag on the final word of each run.
// Configuration: cfg_we writes the failsafe limit from cfg_wdata at once.
// A byte or tick is taken whenever the readout sequencer is idle.
// A good frame yields CHANNELS words, each by a RAM read, then an output load,
// and input stalls from byte 31 until the last word is loaded; failsafe emits
// CHANNELS zero words; a bad frame emits one word.
// A good frame's first word passes the S_RD state, the RAM read register and
// the output register; an error or failsafe word passes S_ERR or S_ZERO, then the output register.
// The readout pace is set by the registered read of the channel RAM.
// A stalled receiver holds the output word and the busy sequencer; input then waits.
// Reset restarts the frame at position 0, sets the limit to 10 and clears the
// missed-frame counter; the channel RAM needs no clearing.
module ibus_frame_receiver_core #(
	parameter int CHANNELS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  frame_status,
	output logic [3:0]  channel_index,
	output logic [15:0] channel_value,
	output logic        last,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic            fire;
	logic            idle;
	logic [7:0]      limit;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [15:0]     ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [15:0]     ram_rdata;
	ibusfr_pkg::ev_t ev;

	assign item_ready = idle;
	assign fire       = item_valid && idle;

	ibusfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.limit     (limit)
	);

	ibusfr_parse #(.CHANNELS(CHANNELS)) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op),
		.rx_byte   (rx_byte),
		.limit     (limit),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ev        (ev)
	);

	ibusfr_ram #(.WIDTH(16), .DEPTH(CHANNELS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ibusfr_readout #(.CHANNELS(CHANNELS)) u_readout (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev            (ev),
		.idle          (idle),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.frame_status  (frame_status),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

	// Channel writes and readout reads never share a cycle
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("channel RAM read and write collide");

	// No word is accepted while results of a frame are still being read out
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> !item_ready)
		else $error("input taken during readout");

	// A completed good frame starts a RAM read on the next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(ev.valid && ev.kind == ibusfr_pkg::EV_GOOD) |=> ram_re)
		else $error("readout did not start");

endmodule

FILE: rtl/core/ibusfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ibusfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 14
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/ibusfr_parse.sv
// Byte and tick front end: frame position, checksum, header check, missed counter.
// Writes channel words into the channel RAM and raises frame events.
// Depends on ibusfr_pkg.
module ibusfr_parse #(
	parameter int CHANNELS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 op,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           limit,
	output logic                 ram_we,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_waddr,
	output logic [15:0]          ram_wdata,
	output ibusfr_pkg::ev_t      ev
);

	localparam int         AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [5:0] CH_END = 6'(2 + 2 * CHANNELS);

	logic [4:0]  pos_q;
	logic [15:0] csum_q;
	logic        hdr_ok_q;
	logic [7:0]  low_q;
	logic [7:0]  csum_lo_q;
	logic [7:0]  missed_q;

	logic        byte_fire;
	logic        tick_fire;
	logic        in_ch_range;
	logic [4:0]  ch_off;
	logic [7:0]  missed_next;
	logic        failsafe;
	logic [15:0] rx_sum;

	assign byte_fire   = fire && (op == ibusfr_pkg::OP_BYTE);
	assign tick_fire   = fire && (op == ibusfr_pkg::OP_TICK);
	assign in_ch_range = (pos_q >= 5'd2) && ({1'b0, pos_q} < CH_END);
	assign ch_off      = pos_q - 5'd2;
	assign missed_next = missed_q + 8'd1;
	assign failsafe    = tick_fire && (missed_next >= limit);
	assign rx_sum      = {rx_byte, csum_lo_q};

	// Store a channel word on its high byte
	assign ram_we    = byte_fire && in_ch_range && pos_q[0];
	assign ram_waddr = ch_off[AW:1];
	assign ram_wdata = {rx_byte, low_q};

	// Raise frame events
	always_comb begin
		ev.valid = 1'b0;
		ev.kind  = ibusfr_pkg::EV_GOOD;
		if (byte_fire && pos_q == ibusfr_pkg::CSUM_HI_POS) begin
			ev.valid = 1'b1;
			if (!hdr_ok_q) begin
				ev.kind = ibusfr_pkg::EV_BAD_HDR;
			end else if (rx_sum != csum_q) begin
				ev.kind = ibusfr_pkg::EV_BAD_SUM;
			end
		end else if (failsafe) begin
			ev.valid = 1'b1;
			ev.kind  = ibusfr_pkg::EV_FAILSAFE;
		end
	end

	// Advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			csum_q    <= ibusfr_pkg::CSUM_INIT;
			hdr_ok_q  <= 1'b1;
			low_q     <= '0;
			csum_lo_q <= '0;
			missed_q  <= '0;
		end else if (byte_fire) begin
			if (pos_q == 5'd0 && rx_byte != ibusfr_pkg::HDR0) begin
				hdr_ok_q <= 1'b0;
			end
			if (pos_q == 5'd1 && rx_byte != ibusfr_pkg::HDR1) begin
				hdr_ok_q <= 1'b0;
			end
			if (pos_q < ibusfr_pkg::CSUM_LO_POS) begin
				csum_q <= csum_q - {8'd0, rx_byte};
			end
			if (in_ch_range && !pos_q[0]) begin
				low_q <= rx_byte;
			end
			if (pos_q == ibusfr_pkg::CSUM_LO_POS) begin
				csum_lo_q <= rx_byte;
			end
			if (pos_q == ibusfr_pkg::CSUM_HI_POS) begin
				pos_q    <= '0;
				csum_q   <= ibusfr_pkg::CSUM_INIT;
				hdr_ok_q <= 1'b1;
				missed_q <= '0;
			end else begin
				pos_q <= pos_q + 5'd1;
			end
		end else if (tick_fire) begin
			if (failsafe) begin
				missed_q <= '0;
				pos_q    <= '0;
				csum_q   <= ibusfr_pkg::CSUM_INIT;
				hdr_ok_q <= 1'b1;
			end else begin
				missed_q <= missed_next;
			end
		end
	end

	// Checksum and header reset together at each frame restart
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid |=> (pos_q == 5'd0 && csum_q == ibusfr_pkg::CSUM_INIT && hdr_ok_q))
		else $error("frame state not restarted after event");

	// A channel write only lands inside the store
	a_waddr: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ch_off[4:1]} < 5'(CHANNELS)))
		else $error("channel write outside store");

endmodule

FILE: rtl/core/ibusfr_readout.sv
// Readout sequencer: turns frame events into result words through the output register.
// Reads channel words from the channel RAM one at a time. Depends on ibusfr_pkg.
module ibusfr_readout #(
	parameter int CHANNELS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ibusfr_pkg::ev_t      ev,
	output logic                 idle,
	output logic                 ram_re,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ram_raddr,
	input  logic [15:0]          ram_rdata,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [1:0]           frame_status,
	output logic [3:0]           channel_index,
	output logic [15:0]          channel_value,
	output logic                 last
);

	localparam int         AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [3:0] LAST_IDX = 4'(CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_LOAD,
		S_ZERO,
		S_ERR
	} state_t;

	state_t      state_q;
	logic [3:0]  idx_q;
	logic [1:0]  err_status_q;
	logic        valid_q;
	logic [1:0]  status_q;
	logic [3:0]  index_q;
	logic [15:0] value_q;
	logic        last_q;
	logic        out_free;
	logic        out_load;

	assign out_free  = !valid_q || result_ready;
	assign out_load  = out_free
		&& (state_q == S_LOAD || state_q == S_ZERO || state_q == S_ERR);
	assign idle      = (state_q == S_IDLE);
	assign ram_re    = (state_q == S_RD);
	assign ram_raddr = idx_q[AW-1:0];

	// Sequence results and hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			err_status_q <= ibusfr_pkg::ST_BAD_HDR;
			valid_q      <= 1'b0;
			status_q     <= ibusfr_pkg::ST_OK;
			index_q      <= '0;
			value_q      <= '0;
			last_q       <= 1'b0;
		end else begin
			// Raise valid on each load, drop it once the word is taken
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ev.valid) begin
						idx_q <= '0;
						case (ev.kind)
							ibusfr_pkg::EV_GOOD: state_q <= S_RD;
							ibusfr_pkg::EV_FAILSAFE: state_q <= S_ZERO;
							ibusfr_pkg::EV_BAD_HDR: begin
								err_status_q <= ibusfr_pkg::ST_BAD_HDR;
								state_q      <= S_ERR;
							end
							default: begin
								err_status_q <= ibusfr_pkg::ST_BAD_SUM;
								state_q      <= S_ERR;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						status_q <= ibusfr_pkg::ST_OK;
						index_q  <= idx_q;
						value_q  <= ram_rdata;
						last_q   <= (idx_q == LAST_IDX);
						if (idx_q == LAST_IDX) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= S_RD;
						end
					end
				end
				S_ZERO: begin
					if (out_free) begin
						status_q <= ibusfr_pkg::ST_FAILSAFE;
						index_q  <= idx_q;
						value_q  <= '0;
						last_q   <= (idx_q == LAST_IDX);
						if (idx_q == LAST_IDX) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						status_q <= err_status_q;
						index_q  <= '0;
						value_q  <= '0;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid  = valid_q;
	assign frame_status  = status_q;
	assign channel_index = index_q;
	assign channel_value = value_q;
	assign last          = last_q;

	// Events only arrive while the sequencer is free
	a_ev_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid |-> (state_q == S_IDLE))
		else $error("frame event while readout busy");

	// Channel index never runs past the store
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (idx_q <= LAST_IDX))
		else $error("readout index out of range");

	// Last word of a channel run carries the top index; errors carry index zero
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (index_q == LAST_IDX
			|| status_q == ibusfr_pkg::ST_BAD_HDR || status_q == ibusfr_pkg::ST_BAD_SUM))
		else $error("last word with wrong index");

endmodule

FILE: rtl/core/ibusfr_ram_placeholder_removed.sv
// Configuration register holder for the iBus frame receiver failsafe limit.
// Depends on ibusfr_pkg.
module ibusfr_cfg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic [7:0] limit
);

	logic [7:0] limit_q;

	// Capture the failsafe limit on each write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ibusfr_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign limit = limit_q;

endmodule

FILE: tb/tb_ibus_frame_receiver_core.sv
`timescale 1ns / 100ps
// Testbench for ibus_frame_receiver_core: byte/tick words in, channel result words out.
// Depends on ibusfr_pkg and the RTL of the core; it predicts each result word itself.
module tb_ibus_frame_receiver_core;

	localparam int CHANNELS    = 14;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 2 * CHANNELS + 4;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  idx;
		logic [15:0] value;
		logic        last;
	} chan_word_t;

	// How a directed row is checked
	typedef enum logic [1:0] {
		BY_MODEL,
		NO_WORDS,
		FAILSAFE_RUN
	} row_check_t;

	typedef struct packed {
		logic       is_tick;
		logic [7:0] data;
		row_check_t check;
	} dir_row_t;

	typedef enum logic [2:0] {
		FL_CLEAN,
		FL_HDR0,
		FL_HDR1,
		FL_SUM,
		FL_BOTH
	} frame_flaw_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic        op;
	logic [7:0]  rx_byte;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  frame_status;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic        last;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	// Receiver model state
	logic [7:0]  fail_limit;
	logic [4:0]  frame_pos;
	logic [15:0] sum_acc;
	logic        hdr_good;
	logic [7:0]  lo_hold;
	logic [7:0]  sum_lo_hold;
	logic [15:0] chan_mem [CHANNELS];
	logic [7:0]  tick_count;

	chan_word_t new_words[$];
	chan_word_t awaited_words[$];

	int send_idle_pct;
	int recv_idle_pct;
	int words_sent;
	bit hold_req;
	bit failed;

	// Ticks first reach the reset limit, then a partial frame, then the limit again
	dir_row_t directed_rows [25] = '{
		'{ibusfr_pkg::OP_TICK, 8'h00, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'hFF, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h55, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'hAA, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h00, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'hFF, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h01, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h80, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h7F, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'hFE, FAILSAFE_RUN},
		'{ibusfr_pkg::OP_BYTE, 8'h20, NO_WORDS},
		'{ibusfr_pkg::OP_BYTE, 8'h40, NO_WORDS},
		'{ibusfr_pkg::OP_BYTE, 8'hFF, NO_WORDS},
		'{ibusfr_pkg::OP_BYTE, 8'h00, NO_WORDS},
		'{ibusfr_pkg::OP_BYTE, 8'h80, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h01, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h02, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h04, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h08, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h10, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h20, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h40, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h80, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'hFF, NO_WORDS},
		'{ibusfr_pkg::OP_TICK, 8'h00, FAILSAFE_RUN}
	};

	ibus_frame_receiver_core #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op(op),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.frame_status(frame_status),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic chan_word_t mk_word(logic [1:0] st, int idx, logic [15:0] v, bit lst);
		chan_word_t w;
		w.status = st;
		w.idx    = 4'(idx);
		w.value  = v;
		w.last   = lst;
		return w;
	endfunction

	// Advance the receiver model by one word; results land in new_words
	function automatic void decode_ibus_word(logic is_tick, logic [7:0] b);
		logic [4:0]  p;
		logic [15:0] rx_sum;
		logic [15:0] sum_seen;
		logic        hdr_seen;
		new_words.delete();
		p = frame_pos;
		if (is_tick == ibusfr_pkg::OP_TICK) begin
			tick_count = tick_count + 8'd1;
			if (tick_count < fail_limit)
				return;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_mem[i] = 16'h0000;
				new_words.push_back(mk_word(ibusfr_pkg::ST_FAILSAFE, i, 16'h0000,
					i == CHANNELS - 1));
			end
			tick_count = 8'd0;
			frame_pos  = 5'd0;
			sum_acc    = ibusfr_pkg::CSUM_INIT;
			hdr_good   = 1'b1;
			return;
		end
		if (p == 5'd0 && b != ibusfr_pkg::HDR0)
			hdr_good = 1'b0;
		if (p == 5'd1 && b != ibusfr_pkg::HDR1)
			hdr_good = 1'b0;
		if (p < ibusfr_pkg::CSUM_LO_POS)
			sum_acc = sum_acc - {8'h00, b};
		if (int'(p) >= 2 && int'(p) < 2 + 2 * CHANNELS) begin
			if (!p[0])
				lo_hold = b;
			else
				chan_mem[(int'(p) - 2) / 2] = {b, lo_hold};
		end
		if (p == ibusfr_pkg::CSUM_LO_POS)
			sum_lo_hold = b;
		if (p == ibusfr_pkg::CSUM_HI_POS) begin
			rx_sum     = {b, sum_lo_hold};
			sum_seen   = sum_acc;
			hdr_seen   = hdr_good;
			frame_pos  = 5'd0;
			sum_acc    = ibusfr_pkg::CSUM_INIT;
			hdr_good   = 1'b1;
			tick_count = 8'd0;
			// Header error wins over checksum error
			if (!hdr_seen)
				new_words.push_back(mk_word(ibusfr_pkg::ST_BAD_HDR, 0, 16'h0000, 1'b1));
			else if (rx_sum != sum_seen)
				new_words.push_back(mk_word(ibusfr_pkg::ST_BAD_SUM, 0, 16'h0000, 1'b1));
			else
				for (int i = 0; i < CHANNELS; i++)
					new_words.push_back(mk_word(ibusfr_pkg::ST_OK, i, chan_mem[i],
						i == CHANNELS - 1));
			return;
		end
		frame_pos = p + 5'd1;
	endfunction

	// Offer one word, hold it until taken, then record what it should produce
	task automatic send_word(input logic is_tick, input logic [7:0] b, input row_check_t check);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		op         <= is_tick;
		rx_byte    <= b;
		do
			@(posedge clk);
		while (!item_ready);
		words_sent++;
		decode_ibus_word(is_tick, b);
		case (check)
			BY_MODEL: begin
				foreach (new_words[i])
					awaited_words.push_back(new_words[i]);
			end
			FAILSAFE_RUN: begin
				for (int i = 0; i < CHANNELS; i++)
					awaited_words.push_back(mk_word(ibusfr_pkg::ST_FAILSAFE, i, 16'h0000,
						i == CHANNELS - 1));
			end
			default: ;
		endcase
	endtask

	// Drop valid and wait until every result word is out and the core is quiet
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_limit(input logic [7:0] v);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		fail_limit = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Send one 32-byte frame, optionally damaged, optionally with a tick inside
	task automatic send_frame(input frame_flaw_t flaw, input bit tick_inside);
		logic [7:0]  fr [32];
		logic [15:0] sum;
		logic [7:0]  ext;
		int          cut;
		fr[0] = ibusfr_pkg::HDR0;
		fr[1] = ibusfr_pkg::HDR1;
		for (int i = 2; i < 30; i++)
			fr[i] = rand_byte();
		// In some frames, push every channel to an end of its range
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ext = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				fr[2 + 2 * i] = ext;
				fr[3 + 2 * i] = ext;
			end
		end
		if (flaw == FL_HDR0 || flaw == FL_BOTH)
			fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
		if (flaw == FL_HDR1)
			fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
		sum = ibusfr_pkg::CSUM_INIT;
		for (int i = 0; i < 30; i++)
			sum = sum - {8'h00, fr[i]};
		fr[30] = sum[7:0];
		fr[31] = sum[15:8];
		if (flaw == FL_SUM || flaw == FL_BOTH)
			fr[30 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
		cut = tick_inside ? int'($urandom_range(1, 31)) : -1;
		for (int i = 0; i < 32; i++) begin
			if (i == cut)
				send_word(ibusfr_pkg::OP_TICK, rand_byte(), BY_MODEL);
			send_word(ibusfr_pkg::OP_BYTE, fr[i], BY_MODEL);
		end
	endtask

	task automatic align_frame();
		while (frame_pos != 5'd0)
			send_word(ibusfr_pkg::OP_BYTE, rand_byte(), BY_MODEL);
	endtask

	// Mostly frames, half of them clean, with tick runs and loose noise between them
	task automatic run_mix(input int budget);
		int stop_at;
		int pick;
		int n;
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				align_frame();
				pick = $urandom_range(0, 7);
				send_frame(pick < 4 ? FL_CLEAN : frame_flaw_t'(pick - 3),
					$urandom_range(0, 99) < 15);
			end else if (pick < 80) begin
				n = $urandom_range(1, 6);
				repeat (n) send_word(ibusfr_pkg::OP_TICK, rand_byte(), BY_MODEL);
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_word($urandom_range(0, 3) == 0 ? ibusfr_pkg::OP_TICK
					: ibusfr_pkg::OP_BYTE, rand_byte(), BY_MODEL);
			end
		end
	endtask

	// Drive result_ready; a hold request stalls it for a long stretch
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Compare each result word with the oldest one awaited
	always @(posedge clk) begin : word_check
		chan_word_t w;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_words.size() == 0) begin
				$error("unexpected word: status %0d index %0d value %0h last %0b",
					frame_status, channel_index, channel_value, last);
				failed = 1'b1;
			end else begin
				w = awaited_words.pop_front();
				if (frame_status !== w.status) begin
					$error("frame_status expected %0d actual %0d", w.status, frame_status);
					failed = 1'b1;
				end
				if (channel_index !== w.idx) begin
					$error("channel_index expected %0d actual %0d", w.idx, channel_index);
					failed = 1'b1;
				end
				if (channel_value !== w.value) begin
					$error("channel_value expected %0h actual %0h", w.value, channel_value);
					failed = 1'b1;
				end
				if (last !== w.last) begin
					$error("last expected %0b actual %0b", w.last, last);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_ibus_frame_receiver_core NOT OK");
		$finish;
	end

	initial begin : stimulus
		item_valid = 1'b0;
		op         = ibusfr_pkg::OP_BYTE;
		rx_byte    = 8'h00;
		cfg_we     = 1'b0;
		cfg_wdata  = 8'h00;
		arst_n     = 1'b0;
		hold_req   = 1'b0;
		failed     = 1'b0;
		words_sent = 0;
		fail_limit  = ibusfr_pkg::LIMIT_RESET;
		frame_pos   = 5'd0;
		sum_acc     = ibusfr_pkg::CSUM_INIT;
		hdr_good    = 1'b1;
		lo_hold     = 8'h00;
		sum_lo_hold = 8'h00;
		tick_count  = 8'd0;
		foreach (chan_mem[i])
			chan_mem[i] = 16'h0000;
		send_idle_pct = 30;
		recv_idle_pct = 77;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows at the reset limit
		for (int r = 0; r < 25; r++)
			send_word(directed_rows[r].is_tick, directed_rows[r].data, directed_rows[r].check);

		// Limit 0: every tick raises a failsafe run
		set_limit(8'd0);
		run_mix(20);

		// Limit 255, the slow side swapped
		send_idle_pct = 77;
		recv_idle_pct = 30;
		set_limit(8'd255);
		run_mix(20);

		// Limit 1, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limit(8'd1);
		run_mix(20);

		// Mid limit; stall the output while good frames keep coming
		set_limit(8'($urandom_range(2, 12)));
		align_frame();
		hold_req = 1'b1;
		send_frame(FL_CLEAN, 1'b0);
		send_frame(FL_CLEAN, 1'b0);
		drain();
		run_mix(20);

		drain();
		if (failed || awaited_words.size() != 0)
			$display("tb_ibus_frame_receiver_core NOT OK");
		else
			$display("tb_ibus_frame_receiver_core OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/ibusfr_pkg.sv
rtl/core/ibusfr_ram.sv
rtl/core/ibusfr_parse.sv
rtl/core/ibusfr_readout.sv
rtl/core/ibusfr_ram_placeholder_removed.sv
rtl/core/ibus_frame_receiver_core.sv
tb/tb_ibus_frame_receiver_core.sv
